/* rtl/core/prd_pkg.sv */
// ---------------------------------------------------------------------------
// prd_pkg
// Shared constants and types for the pulse rate detector core.
// ---------------------------------------------------------------------------
package prd_pkg;

    localparam int RAW_DEPTH    = 16;
    localparam int AVG_DEPTH    = 16;
    localparam int PERIOD_DEPTH = 8;

    localparam int RAW_IDX_W = (RAW_DEPTH > 1) ? $clog2(RAW_DEPTH) : 1;
    localparam int AVG_IDX_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int PER_IDX_W = (PERIOD_DEPTH > 1) ? $clog2(PERIOD_DEPTH) : 1;
    localparam int IDX_W     = (RAW_IDX_W > AVG_IDX_W) ?
                               ((RAW_IDX_W > PER_IDX_W) ? RAW_IDX_W : PER_IDX_W) :
                               ((AVG_IDX_W > PER_IDX_W) ? AVG_IDX_W : PER_IDX_W);

    localparam int SAMPLE_W = 10;
    localparam int TIME_W   = 32;
    localparam int LIMIT_W  = 18;
    localparam int BASE_W   = 18;
    localparam int BPM_W    = 16;
    localparam int FRAC_W   = 8;

    // Accumulator and count sizing
    localparam int RAW_SUM_W = SAMPLE_W + $clog2(RAW_DEPTH + 1);
    localparam int AVG_SUM_W = SAMPLE_W + $clog2(AVG_DEPTH + 1);
    localparam int PER_SUM_W = TIME_W + $clog2(PERIOD_DEPTH + 1);
    localparam int SUM_W     = PER_SUM_W;
    localparam int CNT_W     = $clog2(((RAW_DEPTH > AVG_DEPTH) ? RAW_DEPTH : AVG_DEPTH) + 1);

    // Serial divider: quotient/dividend shift register and step counter
    localparam int QUO_W   = (PER_SUM_W > AVG_SUM_W + FRAC_W) ? PER_SUM_W : AVG_SUM_W + FRAC_W;
    localparam int DCNT_W  = $clog2(QUO_W + 1);
    localparam int BPM_NUM = 1000 * 60;
    localparam int BPM_NUM_W = 16;

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_RSUM = 10'b00_0000_0010,
        S_RDIV = 10'b00_0000_0100,
        S_BSUM = 10'b00_0000_1000,
        S_BDIV = 10'b00_0001_0000,
        S_CMP  = 10'b00_0010_0000,
        S_PSUM = 10'b00_0100_0000,
        S_PDIV = 10'b00_1000_0000,
        S_QDIV = 10'b01_0000_0000,
        S_DONE = 10'b10_0000_0000
    } t_state;

endpackage

/* rtl/core/prd_ifs.sv */
// ---------------------------------------------------------------------------
// prd_ifs
// Valid/ready channels of the pulse rate detector: sample in, result out,
// configuration write.
// ---------------------------------------------------------------------------
interface prd_in_if;
    logic                         valid;
    logic                         ready;
    logic [prd_pkg::SAMPLE_W-1:0] sample;
    logic [prd_pkg::TIME_W-1:0]   now_ms;
    modport source (output valid, sample, now_ms, input ready);
    modport sink   (input valid, sample, now_ms, output ready);
endinterface

interface prd_out_if;
    logic                         valid;
    logic                         ready;
    logic                         beat;
    logic                         in_pulse;
    logic [prd_pkg::SAMPLE_W-1:0] avg_value;
    logic [prd_pkg::BASE_W-1:0]   baseline;
    logic [prd_pkg::TIME_W-1:0]   avg_period;
    logic [prd_pkg::BPM_W-1:0]    bpm;
    modport source (output valid, beat, in_pulse, avg_value, baseline, avg_period, bpm,
                    input ready);
    modport sink   (input valid, beat, in_pulse, avg_value, baseline, avg_period, bpm,
                    output ready);
endinterface

interface prd_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [prd_pkg::LIMIT_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

/* rtl/core/pulse_rate_detector_core.sv */
// ---------------------------------------------------------------------------
// pulse_rate_detector_core
// Moving-average threshold pulse detector with beat period averaging and BPM.
// ---------------------------------------------------------------------------
// channel   dir  words carried
// i_in      in   sample, now_ms
// o_out     out  beat, in_pulse, avg_value, baseline, avg_period, bpm
// i_cfg     in   detection_limit (always ready)
//
// One word at a time: each accepted sample passes through three ring sweeps
// (16 + 16 + 8 entries, one a cycle), four passes of the shared radix-2
// divider (15 + 23 + 36 + 16 steps) and one compare step before its result
// is valid. The next sample is taken once the last is done; a finished result
// waits in the output register while the next one works, and a second finished
// result holds until the first is taken. Reset clears all rings and pointers.
// ---------------------------------------------------------------------------
module pulse_rate_detector_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    prd_in_if.sink     i_in,
    prd_out_if.source  o_out,
    prd_cfg_if.sink    i_cfg
);

    prd_pkg::t_state r_state;

    logic [prd_pkg::SAMPLE_W-1:0] r_raw_ring [prd_pkg::RAW_DEPTH];
    logic [prd_pkg::SAMPLE_W-1:0] r_avg_ring [prd_pkg::AVG_DEPTH];
    logic [prd_pkg::TIME_W-1:0]   r_per_ring [prd_pkg::PERIOD_DEPTH];
    logic [prd_pkg::RAW_IDX_W-1:0] r_raw_pos;
    logic [prd_pkg::AVG_IDX_W-1:0] r_avg_pos;
    logic [prd_pkg::PER_IDX_W-1:0] r_per_pos;
    logic                          r_mark;
    logic [prd_pkg::TIME_W-1:0]    r_last_ms;
    logic [prd_pkg::TIME_W-1:0]    r_now;
    logic [prd_pkg::LIMIT_W-1:0]   r_limit;

    logic [prd_pkg::IDX_W-1:0]  r_idx;
    logic [prd_pkg::SUM_W-1:0]  r_sum;
    logic [prd_pkg::CNT_W-1:0]  r_cnt;

    logic [prd_pkg::QUO_W-1:0]  r_quo;
    logic [prd_pkg::TIME_W-1:0] r_rem;
    logic [prd_pkg::TIME_W-1:0] r_dvs;
    logic [prd_pkg::DCNT_W-1:0] r_dcnt;
    logic                       r_dz;

    logic                         r_beat;
    logic [prd_pkg::SAMPLE_W-1:0] r_avg;
    logic [prd_pkg::BASE_W-1:0]   r_base;
    logic [prd_pkg::TIME_W-1:0]   r_per;
    logic [prd_pkg::BPM_W-1:0]    r_bpm;

    logic                         r_ovalid;
    logic                         r_obeat;
    logic                         r_opulse;
    logic [prd_pkg::SAMPLE_W-1:0] r_oavg;
    logic [prd_pkg::BASE_W-1:0]   r_obase;
    logic [prd_pkg::TIME_W-1:0]   r_oper;
    logic [prd_pkg::BPM_W-1:0]    r_obpm;

    // ring sweep
    logic [prd_pkg::SUM_W-1:0]  n_elem;
    logic [prd_pkg::SUM_W-1:0]  n_sum;
    logic [prd_pkg::CNT_W-1:0]  n_cnt;
    logic                       n_last;

    // divider step
    logic [prd_pkg::TIME_W:0]   n_trial;
    logic                       n_qbit;
    logic [prd_pkg::TIME_W-1:0] n_rem;
    logic [prd_pkg::QUO_W-1:0]  n_quo;
    logic [prd_pkg::QUO_W-1:0]  n_q;
    logic                       n_dlast;

    // threshold
    logic [prd_pkg::BASE_W:0]   n_level;
    logic [prd_pkg::BASE_W:0]   n_scaled;

    always_comb begin
        n_elem = '0;
        n_last = 1'b0;
        case (r_state)
            prd_pkg::S_RSUM: begin
                n_elem = prd_pkg::SUM_W'(r_raw_ring[r_idx[prd_pkg::RAW_IDX_W-1:0]]);
                n_last = (r_idx == prd_pkg::IDX_W'(prd_pkg::RAW_DEPTH - 1));
            end
            prd_pkg::S_BSUM: begin
                n_elem = prd_pkg::SUM_W'(r_avg_ring[r_idx[prd_pkg::AVG_IDX_W-1:0]]);
                n_last = (r_idx == prd_pkg::IDX_W'(prd_pkg::AVG_DEPTH - 1));
            end
            prd_pkg::S_PSUM: begin
                n_elem = prd_pkg::SUM_W'(r_per_ring[r_idx[prd_pkg::PER_IDX_W-1:0]]);
                n_last = (r_idx == prd_pkg::IDX_W'(prd_pkg::PERIOD_DEPTH - 1));
            end
            default: begin
                n_elem = '0;
                n_last = 1'b0;
            end
        endcase
        n_sum = r_sum + n_elem;
        n_cnt = r_cnt + prd_pkg::CNT_W'(n_elem != '0);
    end

    always_comb begin
        n_trial = {r_rem, r_quo[prd_pkg::QUO_W-1]};
        n_qbit  = (n_trial >= {1'b0, r_dvs});
        n_rem   = n_qbit ? prd_pkg::TIME_W'(n_trial - {1'b0, r_dvs})
                         : n_trial[prd_pkg::TIME_W-1:0];
        n_quo   = {r_quo[prd_pkg::QUO_W-2:0], n_qbit};
        n_q     = r_dz ? '0 : n_quo;
        n_dlast = (r_dcnt == prd_pkg::DCNT_W'(1));
    end

    always_comb begin
        n_level  = {1'b0, r_base} + prd_pkg::BASE_W'(r_limit) + (prd_pkg::BASE_W + 1)'(0);
        n_scaled = {1'b0, r_avg, {prd_pkg::FRAC_W{1'b0}}};
    end

    assign i_in.ready       = (r_state == prd_pkg::S_IDLE);
    assign i_cfg.ready      = 1'b1;
    assign o_out.valid      = r_ovalid;
    assign o_out.beat       = r_obeat;
    assign o_out.in_pulse   = r_opulse;
    assign o_out.avg_value  = r_oavg;
    assign o_out.baseline   = r_obase;
    assign o_out.avg_period = r_oper;
    assign o_out.bpm        = r_obpm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= prd_pkg::S_IDLE;
            r_raw_pos <= '0;
            r_avg_pos <= '0;
            r_per_pos <= '0;
            r_mark    <= 1'b0;
            r_last_ms <= '0;
            r_limit   <= '0;
            r_ovalid  <= 1'b0;
            for (int i = 0; i < prd_pkg::RAW_DEPTH; i++) r_raw_ring[i] <= '0;
            for (int i = 0; i < prd_pkg::AVG_DEPTH; i++) r_avg_ring[i] <= '0;
            for (int i = 0; i < prd_pkg::PERIOD_DEPTH; i++) r_per_ring[i] <= '0;
        end else begin
            if (i_cfg.valid) begin
                r_limit <= i_cfg.data;
            end
            // the done state reloads the output register itself
            if (o_out.valid && o_out.ready && (r_state != prd_pkg::S_DONE)) begin
                r_ovalid <= 1'b0;
            end

            // divider advances in every divide state, bar the bpm pass load
            if (((r_state == prd_pkg::S_RDIV) || (r_state == prd_pkg::S_BDIV) ||
                 (r_state == prd_pkg::S_PDIV) || (r_state == prd_pkg::S_QDIV)) &&
                !((r_state == prd_pkg::S_PDIV) && n_dlast)) begin
                r_quo  <= n_quo;
                r_rem  <= n_rem;
                r_dcnt <= r_dcnt - prd_pkg::DCNT_W'(1);
            end

            case (r_state)
                prd_pkg::S_IDLE: begin
                    if (i_in.valid) begin
                        r_raw_ring[r_raw_pos] <= i_in.sample;
                        r_raw_pos <= (r_raw_pos == prd_pkg::RAW_IDX_W'(prd_pkg::RAW_DEPTH - 1))
                                     ? '0 : r_raw_pos + prd_pkg::RAW_IDX_W'(1);
                        r_now   <= i_in.now_ms;
                        r_idx   <= '0;
                        r_sum   <= '0;
                        r_cnt   <= '0;
                        r_state <= prd_pkg::S_RSUM;
                    end
                end
                prd_pkg::S_RSUM: begin
                    r_sum <= n_sum;
                    r_cnt <= n_cnt;
                    r_idx <= r_idx + prd_pkg::IDX_W'(1);
                    if (n_last) begin
                        r_rem   <= '0;
                        r_quo   <= prd_pkg::QUO_W'(n_sum[prd_pkg::RAW_SUM_W-1:0])
                                   << (prd_pkg::QUO_W - prd_pkg::RAW_SUM_W);
                        r_dvs   <= prd_pkg::TIME_W'(n_cnt);
                        r_dz    <= (n_cnt == '0);
                        r_dcnt  <= prd_pkg::DCNT_W'(prd_pkg::RAW_SUM_W);
                        r_state <= prd_pkg::S_RDIV;
                    end
                end
                prd_pkg::S_RDIV: begin
                    if (n_dlast) begin
                        r_avg <= n_q[prd_pkg::SAMPLE_W-1:0];
                        r_avg_ring[r_avg_pos] <= n_q[prd_pkg::SAMPLE_W-1:0];
                        r_avg_pos <= (r_avg_pos == prd_pkg::AVG_IDX_W'(prd_pkg::AVG_DEPTH - 1))
                                     ? '0 : r_avg_pos + prd_pkg::AVG_IDX_W'(1);
                        r_idx   <= '0;
                        r_sum   <= '0;
                        r_cnt   <= '0;
                        r_state <= prd_pkg::S_BSUM;
                    end
                end
                prd_pkg::S_BSUM: begin
                    r_sum <= n_sum;
                    r_cnt <= n_cnt;
                    r_idx <= r_idx + prd_pkg::IDX_W'(1);
                    if (n_last) begin
                        r_rem   <= '0;
                        r_quo   <= prd_pkg::QUO_W'({n_sum[prd_pkg::AVG_SUM_W-1:0],
                                                    {prd_pkg::FRAC_W{1'b0}}})
                                   << (prd_pkg::QUO_W - prd_pkg::AVG_SUM_W - prd_pkg::FRAC_W);
                        r_dvs   <= prd_pkg::TIME_W'(n_cnt);
                        r_dz    <= (n_cnt == '0);
                        r_dcnt  <= prd_pkg::DCNT_W'(prd_pkg::AVG_SUM_W + prd_pkg::FRAC_W);
                        r_state <= prd_pkg::S_BDIV;
                    end
                end
                prd_pkg::S_BDIV: begin
                    if (n_dlast) begin
                        r_base  <= n_q[prd_pkg::BASE_W-1:0];
                        r_state <= prd_pkg::S_CMP;
                    end
                end
                prd_pkg::S_CMP: begin
                    r_beat <= (n_scaled > n_level) && !r_mark;
                    if ((n_scaled > n_level) && !r_mark) begin
                        r_mark <= 1'b1;
                        r_per_ring[r_per_pos] <= r_now - r_last_ms;
                        r_per_pos <= (r_per_pos == prd_pkg::PER_IDX_W'(prd_pkg::PERIOD_DEPTH - 1))
                                     ? '0 : r_per_pos + prd_pkg::PER_IDX_W'(1);
                        r_last_ms <= r_now;
                    end else if (n_scaled < n_level) begin
                        r_mark <= 1'b0;
                    end
                    r_idx   <= '0;
                    r_sum   <= '0;
                    r_cnt   <= '0;
                    r_state <= prd_pkg::S_PSUM;
                end
                prd_pkg::S_PSUM: begin
                    r_sum <= n_sum;
                    r_cnt <= n_cnt;
                    r_idx <= r_idx + prd_pkg::IDX_W'(1);
                    if (n_last) begin
                        r_rem   <= '0;
                        r_quo   <= prd_pkg::QUO_W'(n_sum[prd_pkg::PER_SUM_W-1:0])
                                   << (prd_pkg::QUO_W - prd_pkg::PER_SUM_W);
                        r_dvs   <= prd_pkg::TIME_W'(n_cnt);
                        r_dz    <= (n_cnt == '0);
                        r_dcnt  <= prd_pkg::DCNT_W'(prd_pkg::PER_SUM_W);
                        r_state <= prd_pkg::S_PDIV;
                    end
                end
                prd_pkg::S_PDIV: begin
                    if (n_dlast) begin
                        r_per   <= n_q[prd_pkg::TIME_W-1:0];
                        r_rem   <= '0;
                        r_quo   <= prd_pkg::QUO_W'(prd_pkg::BPM_NUM_W'(prd_pkg::BPM_NUM))
                                   << (prd_pkg::QUO_W - prd_pkg::BPM_NUM_W);
                        r_dvs   <= n_q[prd_pkg::TIME_W-1:0];
                        r_dz    <= (n_q[prd_pkg::TIME_W-1:0] == '0);
                        r_dcnt  <= prd_pkg::DCNT_W'(prd_pkg::BPM_NUM_W);
                        r_state <= prd_pkg::S_QDIV;
                    end
                end
                prd_pkg::S_QDIV: begin
                    if (n_dlast) begin
                        r_bpm   <= n_q[prd_pkg::BPM_W-1:0];
                        r_state <= prd_pkg::S_DONE;
                    end
                end
                prd_pkg::S_DONE: begin
                    // hold until the output register is free
                    if (!r_ovalid || o_out.ready) begin
                        r_ovalid <= 1'b1;
                        r_obeat  <= r_beat;
                        r_opulse <= r_mark;
                        r_oavg   <= r_avg;
                        r_obase  <= r_base;
                        r_oper   <= r_per;
                        r_obpm   <= r_bpm;
                        r_state  <= prd_pkg::S_IDLE;
                    end
                end
                default: begin
                    r_state <= prd_pkg::S_IDLE;
                end
            endcase
        end
    end

endmodule

/* verif/prd_tb_ifs.sv */
// ---------------------------------------------------------------------------
// prd_tb_ifs
// Testbench-side copy point for the detector channels: the RTL interfaces
// are used directly, this file fixes time units and holds the bench's types.
// ---------------------------------------------------------------------------
package prd_tb_pkg;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [9:0]  sample;
        logic [31:0] now_ms;
    } t_reading;

    typedef struct {
        logic        beat;
        logic        in_pulse;
        logic [9:0]  avg_value;
        logic [17:0] baseline;
        logic [31:0] avg_period;
        logic [15:0] bpm;
    } t_pulse_status;
endpackage

/* verif/tb.sv */
// ---------------------------------------------------------------------------
// tb
// Pulse rate detector core: readings are driven through the sample channel
// while a software copy of the rings, pulse mark and period store predicts
// every status word, which is checked field by field on the output channel.
// ---------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import prd_pkg::*;
    import prd_tb_pkg::*;

    localparam int LIMIT_CYCLES = 1500000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    prd_in_if  in_ch ();
    prd_out_if out_ch ();
    prd_cfg_if cfg_ch ();

    pulse_rate_detector_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [17:0] limit_q;
    logic [9:0]  raw_q [RAW_DEPTH];
    logic [9:0]  avgs_q [AVG_DEPTH];
    logic [31:0] periods_q [PERIOD_DEPTH];
    int          raw_wr, avg_wr, per_wr;
    logic        mark_q;
    logic [31:0] last_beat_q;

    t_reading      reading_q[$];
    t_pulse_status status_q[$];
    int            errors = 0;
    int            checked = 0;
    int            beats_seen = 0;
    int            sent = 0;
    int            cycles = 0;
    int            send_idle = 15;
    int            recv_idle = 72;
    int            hold_off = 0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
        $display("mismatch on %s at word %0d: got %0h expected %0h", what, checked, got, exp);
        errors++;
    endtask

    task automatic clear_detector();
        foreach (raw_q[i]) raw_q[i] = '0;
        foreach (avgs_q[i]) avgs_q[i] = '0;
        foreach (periods_q[i]) periods_q[i] = '0;
        raw_wr = 0;
        avg_wr = 0;
        per_wr = 0;
        mark_q = 1'b0;
        last_beat_q = '0;
        limit_q = '0;
    endtask

    function automatic t_pulse_status track_reading(input t_reading r);
        t_pulse_status s;
        int unsigned sum, cnt, base, level, scaled;
        longint unsigned psum, pcnt;
        logic [9:0] avg;
        s.beat = 1'b0;
        raw_q[raw_wr] = r.sample;
        raw_wr = (raw_wr + 1) % RAW_DEPTH;
        sum = 0; cnt = 0;
        foreach (raw_q[i]) if (raw_q[i] != 0) begin sum += raw_q[i]; cnt++; end
        avg = cnt ? 10'(sum / cnt) : '0;
        avgs_q[avg_wr] = avg;
        avg_wr = (avg_wr + 1) % AVG_DEPTH;
        sum = 0; cnt = 0;
        foreach (avgs_q[i]) if (avgs_q[i] != 0) begin sum += avgs_q[i]; cnt++; end
        base = cnt ? (sum * 256) / cnt : 0;
        level = base + limit_q;
        scaled = avg * 256;
        if (scaled > level && !mark_q) begin
            s.beat = 1'b1;
            mark_q = 1'b1;
            periods_q[per_wr] = r.now_ms - last_beat_q;
            per_wr = (per_wr + 1) % PERIOD_DEPTH;
            last_beat_q = r.now_ms;
        end else if (scaled < level) begin
            mark_q = 1'b0;
        end
        psum = 0; pcnt = 0;
        foreach (periods_q[i]) if (periods_q[i] != 0) begin psum += periods_q[i]; pcnt++; end
        s.avg_period = pcnt ? 32'(psum / pcnt) : '0;
        s.bpm = (s.avg_period != 0) ? 16'(60000 / s.avg_period) : '0;
        s.in_pulse = mark_q;
        s.avg_value = avg;
        s.baseline = 18'(base);
        return s;
    endfunction

    // driver: offer the oldest pending reading, advance on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (in_ch.valid && !in_ch.ready) begin
            // hold the word until taken
        end else if (reading_q.size() > 0 && $urandom_range(99) >= send_idle) begin
            if (in_ch.valid) begin
                status_q.push_back(track_reading('{in_ch.sample, in_ch.now_ms}));
                sent++;
            end
            in_ch.valid  <= 1'b1;
            in_ch.sample <= reading_q[0].sample;
            in_ch.now_ms <= reading_q[0].now_ms;
            void'(reading_q.pop_front());
        end else begin
            if (in_ch.valid) begin
                status_q.push_back(track_reading('{in_ch.sample, in_ch.now_ms}));
                sent++;
            end
            in_ch.valid <= 1'b0;
        end
    end

    // long receiver hold-off counter
    always @(posedge i_clk) begin
        if (hold_off > 0) hold_off <= hold_off - 1;
    end

    // monitor: check each accepted status word against the oldest prediction
    always @(posedge i_clk) begin
        t_pulse_status e;
        cycles <= cycles + 1;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (status_q.size() == 0) begin
                    report("unexpected word", 0, 0);
                end else begin
                    e = status_q.pop_front();
                    if (out_ch.beat !== e.beat) report("beat", out_ch.beat, e.beat);
                    if (out_ch.in_pulse !== e.in_pulse)
                        report("in_pulse", out_ch.in_pulse, e.in_pulse);
                    if (out_ch.avg_value !== e.avg_value)
                        report("avg_value", out_ch.avg_value, e.avg_value);
                    if (out_ch.baseline !== e.baseline)
                        report("baseline", out_ch.baseline, e.baseline);
                    if (out_ch.avg_period !== e.avg_period)
                        report("avg_period", out_ch.avg_period, e.avg_period);
                    if (out_ch.bpm !== e.bpm) report("bpm", out_ch.bpm, e.bpm);
                    if (e.beat) beats_seen++;
                end
                checked++;
            end
            out_ch.ready <= (hold_off == 0) && ($urandom_range(99) >= recv_idle);
        end
        if (cycles >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
    end

    task automatic push_reading(input logic [9:0] s, input logic [31:0] t);
        reading_q.push_back('{s, t});
    endtask

    task automatic wait_drained();
        while (reading_q.size() > 0 || in_ch.valid || status_q.size() > 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [17:0] v);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        do @(posedge i_clk); while (!cfg_ch.ready);
        limit_q = v;
        cfg_ch.valid <= 1'b0;
    endtask

    // well-formed pulse train: repeated peaks over a near-flat baseline, with random content
    task automatic push_pulse_train(input int n, inout logic [31:0] t);
        int peak, floor_lvl;
        floor_lvl = $urandom_range(100, 500);
        for (int i = 0; i < n; i++) begin
            peak = ((i % 12) < 3) ? floor_lvl + $urandom_range(100, 500) :
                                    floor_lvl + $urandom_range(0, 20);
            t += $urandom_range(1, 80);
            push_reading(10'(peak > 1023 ? 1023 : peak), t);
        end
    endtask

    initial begin
        logic [31:0] t;
        in_ch.valid   = 1'b0;
        in_ch.sample  = '0;
        in_ch.now_ms  = '0;
        out_ch.ready  = 1'b0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.data   = '0;
        clear_detector();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty ring, extremes, zero period, time wrap, equality hold
        push_reading(10'd0, 32'd0);
        push_reading(10'd1023, 32'd0);
        push_reading(10'd0, 32'd5);
        push_reading(10'd1, 32'hFFFF_FFFF);
        push_reading(10'd1023, 32'hFFFF_FFF0);
        push_reading(10'd1023, 32'd10);
        push_reading(10'h155, 32'h5555_5555);
        push_reading(10'h2AA, 32'hAAAA_AAAA);
        for (int i = 0; i < 8; i++) push_reading(10'd5, 32'd100 + i);
        push_reading(10'd1023, 32'd1000);
        push_reading(10'd1023, 32'd1000);
        wait_drained();

        write_limit(18'h3FFFF);
        push_reading(10'd1023, 32'd2000);
        push_reading(10'd0, 32'd2001);
        wait_drained();

        // random, three idling regimes, several threshold settings
        t = 32'hFFFF_0000;
        for (int phase = 0; phase < 6; phase++) begin
            send_idle = (phase < 2) ? 15 : (phase < 4) ? 72 : 0;
            recv_idle = (phase < 2) ? 72 : (phase < 4) ? 15 : 0;
            case (phase)
                0: write_limit(18'd0);
                1: write_limit(18'($urandom_range(256, 8000)));
                2: write_limit(18'($urandom_range(0, 255)));
                3: write_limit(18'h3FFFF);
                4: write_limit(18'($urandom_range(0, 20000)));
                default: write_limit(18'($urandom));
            endcase
            if (phase == 4) hold_off = 3000;
            push_pulse_train(170, t);
            for (int i = 0; i < 50; i++) begin
                t += ($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 50);
                push_reading(10'($urandom), t);
            end
            wait_drained();
        end

        $display("%0d status words checked, %0d beats, limits from zero to full scale",
                 checked, beats_seen);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
